### src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u8u16_pkg;

    // Decoded-op queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Op kinds issued by the front decoder
    localparam logic [1:0] OP_UNIT = 2'd0;
    localparam logic [1:0] OP_PAIR = 2'd1;
    localparam logic [1:0] OP_ERR  = 2'd2;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [5:0]  HI_PFX    = 6'b110110;  // 0xD800 >> 10
    localparam logic [5:0]  LO_PFX    = 6'b110111;  // 0xDC00 >> 10

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] payload;   // unit in low 16 bits, or supplementary offset
        logic        last;
    } t_op;

endpackage
`default_nettype wire

### src/u8u16_fifo.sv
// Short queue of decoded ops between the front decoder and the back emitter.
`default_nettype none
module u8u16_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire u8u16_pkg::t_op    i_wr_data,
    input  wire                    i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output u8u16_pkg::t_op         o_rd_data
);

    u8u16_pkg::t_op                     r_mem [u8u16_pkg::QDEPTH];
    logic [u8u16_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [u8u16_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [u8u16_pkg::QCNT_W-1:0]       r_count;

    assign o_full    = (r_count == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### src/u8u16_front.sv
// Front decoder: takes UTF-8 bytes, tracks the open sequence, issues ops.
`default_nettype none
module u8u16_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_data,
    input  wire                 i_last,
    output logic                o_ready,
    input  wire                 i_full,
    output logic                o_push,
    output u8u16_pkg::t_op      o_op
);

    logic [20:0] r_accum, n_accum;
    logic [1:0]  r_left,  n_left;
    logic        r_four,  n_four;
    logic        r_drop,  n_drop;

    logic        accept;
    logic [20:0] acc_shift;
    logic [20:0] supp_off;
    logic [1:0]  left_m1;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign acc_shift = {r_accum[14:0], i_data[5:0]};
    assign supp_off  = acc_shift - u8u16_pkg::SUPP_BASE;
    assign left_m1   = r_left - 2'd1;

    always_comb begin
        n_accum = r_accum;
        n_left  = r_left;
        n_four  = r_four;
        n_drop  = r_drop;
        o_push  = 1'b0;
        o_op    = '0;
        if (accept) begin
            if (r_drop) begin
                // discard up to and including the end mark
                if (i_last) begin
                    n_drop = 1'b0;
                end
            end else if (r_left != 2'd0) begin
                if (left_m1 != 2'd0) begin
                    if (i_last) begin
                        n_accum   = '0;
                        n_left    = '0;
                        n_four    = 1'b0;
                        o_push    = 1'b1;
                        o_op.kind = u8u16_pkg::OP_ERR;
                        o_op.last = 1'b1;
                    end else begin
                        n_accum = acc_shift;
                        n_left  = left_m1;
                    end
                end else begin
                    n_accum = '0;
                    n_left  = '0;
                    n_four  = 1'b0;
                    o_push  = 1'b1;
                    o_op.last = i_last;
                    if (r_four) begin
                        o_op.kind    = u8u16_pkg::OP_PAIR;
                        o_op.payload = supp_off[19:0];
                    end else begin
                        o_op.kind    = u8u16_pkg::OP_UNIT;
                        o_op.payload = {4'd0, acc_shift[15:0]};
                    end
                end
            end else begin
                if (!i_data[7]) begin
                    o_push       = 1'b1;
                    o_op.kind    = u8u16_pkg::OP_UNIT;
                    o_op.payload = {12'd0, i_data};
                    o_op.last    = i_last;
                end else if (i_data[7:5] == 3'b110 || i_data[7:4] == 4'b1110
                             || i_data[7:3] == 5'b11110) begin
                    if (i_last) begin
                        // sequence cut short on its lead byte
                        o_push    = 1'b1;
                        o_op.kind = u8u16_pkg::OP_ERR;
                        o_op.last = 1'b1;
                    end else if (i_data[7:5] == 3'b110) begin
                        n_accum = {16'd0, i_data[4:0]};
                        n_left  = 2'd1;
                        n_four  = 1'b0;
                    end else if (i_data[7:4] == 4'b1110) begin
                        n_accum = {17'd0, i_data[3:0]};
                        n_left  = 2'd2;
                        n_four  = 1'b0;
                    end else begin
                        n_accum = {18'd0, i_data[2:0]};
                        n_left  = 2'd3;
                        n_four  = 1'b1;
                    end
                end else begin
                    // bad lead: report, then drop to the end mark
                    o_push    = 1'b1;
                    o_op.kind = u8u16_pkg::OP_ERR;
                    o_op.last = i_last;
                    n_drop    = !i_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_left  <= '0;
            r_four  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_accum <= n_accum;
            r_left  <= n_left;
            r_four  <= n_four;
            r_drop  <= n_drop;
        end
    end

endmodule
`default_nettype wire

### src/u8u16_back.sv
// Back emitter: turns queued ops into UTF-16 beats in an output register.
`default_nettype none
module u8u16_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  wire u8u16_pkg::t_op i_op,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_unit,
    output logic                o_err,
    output logic                o_last
);

    logic        r_valid,    n_valid;
    logic        r_phase,    n_phase;
    logic [15:0] r_unit,     n_unit;
    logic        r_err,      n_err;
    logic        r_last,     n_last;
    logic [9:0]  r_low,      n_low;
    logic        r_low_last, n_low_last;
    logic        load;

    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_err   = r_err;
    assign o_last  = r_last;

    always_comb begin
        n_valid    = r_valid;
        n_phase    = r_phase;
        n_unit     = r_unit;
        n_err      = r_err;
        n_last     = r_last;
        n_low      = r_low;
        n_low_last = r_low_last;
        o_pop      = 1'b0;
        if (load) begin
            if (r_phase) begin
                // second half of a surrogate pair
                n_valid = 1'b1;
                n_unit  = {u8u16_pkg::LO_PFX, r_low};
                n_err   = 1'b0;
                n_last  = r_low_last;
                n_phase = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                case (i_op.kind)
                    u8u16_pkg::OP_PAIR: begin
                        n_unit     = {u8u16_pkg::HI_PFX, i_op.payload[19:10]};
                        n_err      = 1'b0;
                        n_last     = 1'b0;
                        n_phase    = 1'b1;
                        n_low      = i_op.payload[9:0];
                        n_low_last = i_op.last;
                    end
                    u8u16_pkg::OP_ERR: begin
                        n_unit = '0;
                        n_err  = 1'b1;
                        n_last = i_op.last;
                    end
                    default: begin
                        n_unit = i_op.payload[15:0];
                        n_err  = 1'b0;
                        n_last = i_op.last;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit     <= n_unit;
        r_err      <= n_err;
        r_last     <= n_last;
        r_low      <= n_low;
        r_low_last <= n_low_last;
    end

endmodule
`default_nettype wire

### src/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder: top level joining decoder, op queue and emitter.
//
// Slave channel: one UTF-8 byte per beat in tdata, tlast marks the final byte
// of a stream. Master channel: one UTF-16 code unit per beat in tdata, tuser
// flags an error beat (unit is zero then), tlast marks the final result.
// The decoder takes a byte every cycle while the four-entry op queue has
// room; bytes that open or continue a sequence produce no beat until the
// sequence completes. A completing byte pushes its op into the queue, and the
// emitter loads it into the output register once that register is free.
// Throughput is one byte per cycle while the queue has room; a four-byte
// sequence yields two beats (surrogate pair) in turn from the single output register,
// and the queue absorbs that extra beat. A bad lead byte gives one error beat
// and the rest of the stream up to tlast is dropped; a stream cut short gives
// one error beat with tlast. When the receiver stalls, the output register
// holds its beat, the queue fills and tready drops after four more ops.
// Synchronous reset clears the open sequence, drop mode, queue and output.
`default_nettype none
module utf8_to_utf16_transcoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic        o_m_axis_tuser,   // [0] is_error
    output logic        o_m_axis_tlast
);

    logic           full;
    logic           empty;
    logic           push;
    logic           pop;
    u8u16_pkg::t_op wr_op;
    u8u16_pkg::t_op rd_op;

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_op    (wr_op)
    );

    u8u16_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_op),
        .i_pop     (pop),
        .o_full    (full),
        .o_empty   (empty),
        .o_rd_data (rd_op)
    );

    u8u16_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_op    (rd_op),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_unit  (o_m_axis_tdata),
        .o_err   (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

### src/u8u16_checker.sv
// Port-level checks for the transcoder, bound to the top level.
`default_nettype none
module u8u16_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [15:0] o_m_axis_tdata,
    input wire        o_m_axis_tuser,
    input wire        o_m_axis_tlast
);

    // a stalled beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat withdrawn while stalled");

    // error beats carry a zero unit
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 16'd0)
        else $error("error beat with nonzero code unit");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // hold the error and last flags of a stalled beat
    a_last_err_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled beat flags changed");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_u8u16_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

### tb/sv/utf8_to_utf16_transcoder_top_checker.sv
// Stream monitor for the UTF-8 to UTF-16 transcoder: predicts code units and checks each beat.
module utf8_to_utf16_transcoder_top_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] data_byte
    input  wire         i_s_tlast,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,    // [15:0] code_unit
    input  wire         i_m_tuser,    // [0] is_error
    input  wire         i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET  = 21'h10000;

    typedef struct packed {
        logic [15:0] unit;
        logic        err;
        logic        last;
    } unit_beat_t;

    unit_beat_t  expected_units_q[$];
    unit_beat_t  want_beat;
    logic [20:0] seq_accum  = '0;
    logic [1:0]  seq_left   = '0;
    logic        seq_four   = 1'b0;
    logic        drop_mode  = 1'b0;
    int          mismatches = 0;

    task automatic push_unit(input logic [15:0] unit, input logic err, input logic last);
        unit_beat_t beat;
        beat.unit = unit;
        beat.err  = err;
        beat.last = last;
        expected_units_q.push_back(beat);
    endtask

    task automatic clear_seq();
        seq_accum = '0;
        seq_left  = '0;
        seq_four  = 1'b0;
    endtask

    // Advance the decoder by one byte and queue the code units it yields.
    task automatic predict_units(input logic [7:0] b, input logic eos);
        logic [20:0] diff;
        if (drop_mode) begin
            if (eos)
                drop_mode = 1'b0;
            return;
        end
        if (seq_left != 2'd0) begin
            seq_accum = {seq_accum[14:0], b[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left != 2'd0) begin
                if (eos) begin
                    clear_seq();
                    push_unit(16'h0000, 1'b1, 1'b1);
                end
                return;
            end
            if (seq_four) begin
                // offset wraps modulo 2^20, out-of-range values included
                diff = seq_accum - SUPP_OFFSET;
                clear_seq();
                push_unit(HI_SURR_BASE + {6'd0, diff[19:10]}, 1'b0, 1'b0);
                push_unit(LO_SURR_BASE + {6'd0, diff[9:0]}, 1'b0, eos);
            end else begin
                push_unit(seq_accum[15:0], 1'b0, eos);
                clear_seq();
            end
            return;
        end
        if (b[7] == 1'b0) begin
            push_unit({8'h00, b}, 1'b0, eos);
            return;
        end
        if (b[7:5] == 3'b110) begin
            seq_accum = {16'd0, b[4:0]};
            seq_left  = 2'd1;
            seq_four  = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
            seq_accum = {17'd0, b[3:0]};
            seq_left  = 2'd2;
            seq_four  = 1'b0;
        end else if (b[7:3] == 5'b11110) begin
            seq_accum = {18'd0, b[2:0]};
            seq_left  = 2'd3;
            seq_four  = 1'b1;
        end else begin
            // bad lead: one error beat, then drop up to the end mark
            clear_seq();
            drop_mode = !eos;
            push_unit(16'h0000, 1'b1, eos);
            return;
        end
        if (eos) begin
            clear_seq();
            push_unit(16'h0000, 1'b1, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_seq();
            drop_mode = 1'b0;
            expected_units_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_units(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_units_q.size() == 0) begin
                    $error("unexpected beat: code_unit %h is_error %b last %b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    mismatches++;
                end else begin
                    want_beat = expected_units_q.pop_front();
                    if (i_m_tdata !== want_beat.unit) begin
                        $error("code_unit mismatch: expected %h, actual %h",
                               want_beat.unit, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tuser !== want_beat.err) begin
                        $error("is_error mismatch: expected %b, actual %b",
                               want_beat.err, i_m_tuser);
                        mismatches++;
                    end
                    if (i_m_tlast !== want_beat.last) begin
                        $error("last mismatch: expected %b, actual %b",
                               want_beat.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_units_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/utf8_to_utf16_transcoder_top_test.sv
// Stimulus and verdict for the UTF-8 to UTF-16 transcoder.
module utf8_to_utf16_transcoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending_units;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int bytes_sent    = 0;

    always #10 i_clk = ~i_clk;

    utf8_to_utf16_transcoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),    // [15:0] code_unit
        .o_m_axis_tuser  (m_axis_tuser),    // [0] is_error
        .o_m_axis_tlast  (m_axis_tlast)
    );

    utf8_to_utf16_transcoder_top_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_units)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Present one byte and hold it until the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_stream(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    // Append the first keep bytes of a random len-byte sequence.
    task automatic add_char(ref logic [7:0] q[$], input int len, input int keep);
        logic [7:0] lead;
        case (len)
            1: begin
                lead = {1'b0, 7'($urandom_range(0, 127))};
            end
            2: begin
                lead = {3'b110, 5'($urandom_range(0, 31))};
            end
            3: begin
                lead = {4'b1110, 4'($urandom_range(0, 15))};
            end
            default: begin
                lead = {5'b11110, 3'($urandom_range(0, 7))};
            end
        endcase
        q.push_back(lead);
        for (int i = 1; i < keep; i++) begin
            // continuation prefix is ignored by the block; mix in odd ones
            if ($urandom_range(0, 19) == 0)
                q.push_back(8'($urandom_range(0, 255)));
            else
                q.push_back({2'b10, 6'($urandom_range(0, 63))});
        end
    endtask

    task automatic send_random_stream();
        logic [7:0] q[$];
        int n_chars;
        int mode;
        int len;
        int r;
        n_chars = $urandom_range(1, 6);
        mode    = $urandom_range(0, 99);
        if (mode < 6) begin
            // raw noise
            for (int i = 0; i < n_chars; i++)
                q.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < n_chars; i++) begin
                r   = $urandom_range(0, 99);
                len = (r < 35) ? 1 : (r < 55) ? 2 : (r < 75) ? 3 : 4;
                add_char(q, len, len);
            end
            if (mode < 16) begin
                // bad lead, then a tail that must be dropped
                if ($urandom_range(0, 1) == 0)
                    q.push_back({2'b10, 6'($urandom_range(0, 63))});
                else
                    q.push_back({5'b11111, 3'($urandom_range(0, 7))});
                r = $urandom_range(0, 4);
                for (int i = 0; i < r; i++)
                    q.push_back(8'($urandom_range(0, 255)));
            end else if (mode < 26) begin
                // cut the closing sequence short
                len = $urandom_range(2, 4);
                add_char(q, len, $urandom_range(1, len - 1));
            end
        end
        send_stream(q);
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
            send_random_stream();
    endtask

    // Hold off the sender until every queued code unit has come out.
    task automatic drain_outputs();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_units != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] q[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 12;
        sink_idle_pct <= 82;

        // ASCII extremes, end mark on a single byte
        q = '{8'h00, 8'h7F};
        send_stream(q);
        // overlong two-byte with a non-10 continuation, then the top two-byte value
        q = '{8'hC0, 8'h00, 8'hDF, 8'hBF};
        send_stream(q);
        // top of the BMP
        q = '{8'hEF, 8'hBF, 8'hBF};
        send_stream(q);
        // first supplementary value
        q = '{8'hF0, 8'h90, 8'h80, 8'h80};
        send_stream(q);
        // four-byte values below and above the plane range wrap
        q = '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_stream(q);
        // stray continuation as lead: error, then drop through the end mark
        q = '{8'h80, 8'h41, 8'hFF};
        send_stream(q);
        // bad lead carrying the end mark
        q = '{8'hF8};
        send_stream(q);
        // end mark on a lead byte, then on an incomplete continuation
        q = '{8'hE2};
        send_stream(q);
        q = '{8'hF0, 8'h90};
        send_stream(q);

        run_random(130);
        drain_outputs();

        src_idle_pct  = 82;
        sink_idle_pct <= 12;
        run_random(135);
        drain_outputs();

        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        run_random(135);
        drain_outputs();

        if (fail_count == 0 && pending_units == 0) begin
            $display("utf8_to_utf16_transcoder_top test passed");
        end else begin
            $display("utf8_to_utf16_transcoder_top test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("utf8_to_utf16_transcoder_top test failed");
        $finish;
    end

endmodule

### filelist.f
src/u8u16_pkg.sv
src/u8u16_fifo.sv
src/u8u16_front.sv
src/u8u16_back.sv
src/utf8_to_utf16_transcoder_top.sv
src/u8u16_checker.sv
tb/sv/utf8_to_utf16_transcoder_top_checker.sv
tb/sv/utf8_to_utf16_transcoder_top_test.sv
